// ===== rtl/core/rrs_pkg.sv =====
`default_nettype none

package rrs_pkg;

    // Default coordinate width of all fields
    localparam int COORD_BITS_DEF = 12;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLAMP = 6'b000010,
        S_SETUP = 6'b000100,
        S_MUL   = 6'b001000,
        S_SQRT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/rrs_req_if.sv =====
`default_nettype none

// Request channel: one row query per item
interface rrs_req_if #(
    parameter int W = rrs_pkg::COORD_BITS_DEF
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] row;
    logic [W-1:0] rect_width;
    logic [W-1:0] rect_height;
    logic [W-1:0] radius;

    modport source (output valid, output row, output rect_width, output rect_height,
                    output radius, input ready);
    modport sink   (input valid, input row, input rect_width, input rect_height,
                    input radius, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrs_rsp_if.sv =====
`default_nettype none

// Response channel: one span per item
interface rrs_rsp_if #(
    parameter int W = rrs_pkg::COORD_BITS_DEF
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] span_start;
    logic [W-1:0] span_end;

    modport source (output valid, output span_start, output span_end, input ready);
    modport sink   (input valid, input span_start, input span_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrs_mul.sv =====
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle
module rrs_mul #(
    parameter int W = rrs_pkg::COORD_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic                o_done,
    output logic [2*W-1:0]      o_product
);
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic [2*W-1:0] r_p, n_p;
    logic [W-1:0]   r_a;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [W:0]     sum;

    // Partial sum on the upper half, multiplier bits leave at the bottom
    assign sum = {1'b0, r_p[2*W-1:W]} + (r_p[0] ? {1'b0, r_a} : {(W+1){1'b0}});

    always_comb begin
        n_p    = r_p;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_p    = {{W{1'b0}}, i_b};
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_p   = {sum, r_p[W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (i_start) begin
            r_a <= i_a;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

`default_nettype wire

// ===== rtl/core/rrs_isqrt.sv =====
`default_nettype none

// Restoring integer square root, one root bit per cycle
module rrs_isqrt #(
    parameter int W = rrs_pkg::COORD_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2*W-1:0] i_radicand,
    output logic                o_done,
    output logic [W-1:0]        o_root
);
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic [2*W-1:0] r_d, n_d;
    logic [W-1:0]   r_q, n_q;
    logic [W:0]     r_rem, n_rem;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [W+2:0]   rem_sh;
    logic [W+2:0]   trial;
    logic [W+2:0]   diff;

    // Bring down two radicand bits, try root*4+1
    assign rem_sh = {r_rem, r_d[2*W-1:2*W-2]};
    assign trial  = {1'b0, r_q, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb begin
        n_d    = r_d;
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_d    = i_radicand;
            n_q    = '0;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_d   = {r_d[2*W-3:0], 2'b00};
            n_cnt = r_cnt + 1'b1;
            if (rem_sh >= trial) begin
                n_rem = diff[W:0];
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[W:0];
                n_q   = {r_q[W-2:0], 1'b0};
            end
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_d   <= n_d;
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_root = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/rounded_rect_row_span_core.sv =====
`default_nettype none

// Channel   Dir  Fields                                      Handshake
// i_req     in   row, rect_width, rect_height, radius        valid/ready
// o_rsp     out  span_start, span_end                        valid/ready
//
// Corner rows run a serial multiply of ly*(2r-ly), then a serial square root, one
// bit each per cycle. Other rows go from setup straight to the done state. One
// item is in work at a time; the input is ready again the cycle after the result
// is loaded.
// The output register holds a result while the next item is accepted and worked on;
// a finished span waits in the last state until the held result is taken.
// Reset (synchronous, active low) empties the controller and the output register.
module rounded_rect_row_span_core #(
    parameter int COORD_BITS = rrs_pkg::COORD_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrs_req_if.sink    i_req,
    rrs_rsp_if.source  o_rsp
);
    localparam int N = COORD_BITS;

    rrs_pkg::t_state r_state, n_state;

    logic [N-1:0]   r_y, r_w, r_h, r_r;
    logic [N-1:0]   r_rc, n_rc;
    logic [N-1:0]   r_dx;
    logic           r_full;
    logic           r_ovalid;
    logic [N-1:0]   r_start, r_end;

    logic [N-1:0]   clamp_w;
    logic [N-1:0]   ly;
    logic [N:0]     two_rc;
    logic [N:0]     mul_b_wide;
    logic           in_top, in_mid, in_bot;
    logic           mul_start, mul_done;
    logic [2*N-1:0] product;
    logic           sqrt_done;
    logic [N-1:0]   root;
    logic           out_free;

    // Radius clamp: half the width, then half the height
    always_comb begin
        clamp_w = ({r_r, 1'b0} > {1'b0, r_w}) ? (r_w >> 1) : r_r;
        n_rc    = ({clamp_w, 1'b0} > {1'b0, r_h}) ? (r_h >> 1) : clamp_w;
    end

    // Row bands, with the bottom band mirrored onto the top
    assign two_rc     = {r_rc, 1'b0};
    assign in_top     = (r_y < r_rc);
    assign in_mid     = (r_y < (r_h - r_rc));
    assign in_bot     = (r_y < r_h);
    assign ly         = in_top ? r_y : (r_h - 1'b1 - r_y);
    assign mul_b_wide = two_rc - {1'b0, ly};
    assign mul_start  = (r_state == rrs_pkg::S_SETUP) && (r_rc != '0) &&
                        (in_top || (!in_mid && in_bot));
    assign out_free   = !r_ovalid || o_rsp.ready;

    rrs_mul #(.W(N)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (ly),
        .i_b       (mul_b_wide[N-1:0]),
        .o_done    (mul_done),
        .o_product (product)
    );

    rrs_isqrt #(.W(N)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_done),
        .i_radicand (product),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrs_pkg::S_IDLE:  if (i_req.valid) n_state = rrs_pkg::S_CLAMP;
            rrs_pkg::S_CLAMP: n_state = rrs_pkg::S_SETUP;
            rrs_pkg::S_SETUP: n_state = mul_start ? rrs_pkg::S_MUL : rrs_pkg::S_DONE;
            rrs_pkg::S_MUL:   if (mul_done) n_state = rrs_pkg::S_SQRT;
            rrs_pkg::S_SQRT:  if (sqrt_done) n_state = rrs_pkg::S_DONE;
            rrs_pkg::S_DONE:  if (out_free) n_state = rrs_pkg::S_IDLE;
            default:          n_state = rrs_pkg::S_IDLE;
        endcase
    end

    // Control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrs_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rrs_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item registers and span arithmetic
    always_ff @(posedge i_clk) begin
        if (r_state == rrs_pkg::S_IDLE && i_req.valid) begin
            r_y <= i_req.row;
            r_w <= i_req.rect_width;
            r_h <= i_req.rect_height;
            r_r <= i_req.radius;
        end
        if (r_state == rrs_pkg::S_CLAMP) begin
            r_rc <= n_rc;
        end
        if (r_state == rrs_pkg::S_SETUP) begin
            // Full row for zero radius or the middle band; rows past the height inset by r
            r_full <= (r_rc == '0) || (!in_top && in_mid);
            r_dx   <= '0;
        end
        if (sqrt_done) begin
            r_dx <= root;
        end
        if (r_state == rrs_pkg::S_DONE && out_free) begin
            if (r_full) begin
                r_start <= '0;
                r_end   <= r_w;
            end else begin
                r_start <= r_rc - r_dx;
                r_end   <= r_w - r_rc + r_dx;
            end
        end
    end

    assign i_req.ready      = (r_state == rrs_pkg::S_IDLE);
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.span_start = r_start;
    assign o_rsp.span_end   = r_end;

endmodule

`default_nettype wire
